FILE: rtl/core/vstc_pkg.sv
// Shared widths, register indexes, reset values and unit handshake types for the servo core.
package vstc_pkg;

  // box coordinate width, Q12.4 at 16 bits
  localparam int CoordBits = 16;
  localparam int SumW      = CoordBits + 1;
  localparam int AreaW     = 2 * CoordBits;
  localparam int DimW      = 13;
  localparam int ErrW      = 16;

  // digit-serial multiplier: 4-bit digits of operand b, MSB first
  localparam int MulW      = (CoordBits > 16) ? CoordBits : 16;
  localparam int MulDigits = (MulW + 3) / 4;
  localparam int MulBW     = 4 * MulDigits;
  localparam int ProdW     = MulW + MulBW;

  // bit-serial restoring divider
  localparam int DiffW     = ((SumW > 17) ? SumW : 17) + 1;
  localparam int OffMagW   = DiffW - 1;
  localparam int ErrNumW   = OffMagW + 10;
  localparam int RatioNumW = AreaW + 6;
  localparam int DivW      = (RatioNumW > ErrNumW) ? RatioNumW : ErrNumW;
  localparam int DenW      = 2 * DimW - 1;
  localparam int QuoW      = 17;

  // configuration port
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] RegTargetClass = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDeadband    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainAngular = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGainLinear  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGainDepth   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegWantedRatio = 3'd5;
  localparam logic [CfgIdxW-1:0] RegImageWidth  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 3'd7;

  localparam logic [7:0]      RstTargetClass = 8'd0;
  localparam logic [15:0]     RstDeadband    = 16'd1638;
  localparam logic [15:0]     RstGain        = 16'd256;
  localparam logic [15:0]     RstWantedRatio = 16'd13107;
  localparam logic [DimW-1:0] RstImageDim    = 13'd640;

  typedef struct packed {
    logic            start;
    logic [MulW-1:0] a;
    logic [MulW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] prod;
  } mul_res_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic            ovf;
    logic [QuoW-1:0] quo;
  } div_res_t;

endpackage

FILE: rtl/core/vstc_serial_mul.sv
// Unsigned digit-serial multiplier: one 4-bit digit of b per cycle, MSB first.
module vstc_serial_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vstc_pkg::mul_req_t  req_i,
  output vstc_pkg::mul_res_t  res_o
);

  localparam int MulW   = vstc_pkg::MulW;
  localparam int MulBW  = vstc_pkg::MulBW;
  localparam int ProdW  = vstc_pkg::ProdW;
  localparam int Digits = vstc_pkg::MulDigits;
  localparam int CntW   = $clog2(Digits + 1);
  localparam int PartW  = MulW + 4;

  logic [MulW-1:0]  a_q;
  logic [MulBW-1:0] b_q;
  logic [ProdW-1:0] acc_q, acc_d;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [3:0]       digit;
  logic [PartW-1:0] part;

  always_comb begin
    digit = b_q[MulBW-1 -: 4];
    part  = '0;
    for (int i = 0; i < 4; i++) begin
      if (digit[i]) begin
        part = part + (PartW'(a_q) << i);
      end
    end
    acc_d = {acc_q[ProdW-5:0], 4'b0000} + ProdW'(part);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Digits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= MulBW'(req_i.b);
      acc_q <= '0;
    end else if (busy_q) begin
      b_q   <= b_q << 4;
      acc_q <= acc_d;
    end
  end

  assign res_o.done = done_q;
  assign res_o.prod = acc_q;

endmodule

FILE: rtl/core/vstc_serial_div.sv
// Unsigned bit-serial restoring divider with a narrow quotient and overflow flag.
module vstc_serial_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vstc_pkg::div_req_t  req_i,
  output vstc_pkg::div_res_t  res_o
);

  localparam int DivW = vstc_pkg::DivW;
  localparam int DenW = vstc_pkg::DenW;
  localparam int QuoW = vstc_pkg::QuoW;
  localparam int CntW = $clog2(DivW + 1);

  logic [DivW-1:0] num_q;
  logic [DenW-1:0] den_q, rem_q, rem_d;
  logic [QuoW-1:0] quo_q;
  logic            ovf_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DenW:0]   trial, diff;
  logic            ge;

  always_comb begin
    trial = {rem_q, num_q[DivW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? diff[DenW-1:0] : trial[DenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits leaving the top of the register mark overflow
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= rem_d;
      quo_q <= {quo_q[QuoW-2:0], ge};
      ovf_q <= ovf_q | quo_q[QuoW-1];
    end
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.quo  = quo_q;

endmodule

FILE: rtl/core/visual_servo_target_control_core.sv
// Servo core top: box tracking, frame-end error sequencer, register file and output stage.
// A box that can win goes through 4 digit steps of the shared multiplier; other boxes do not.
// A frame end with a target runs three 38-step divisions and four 4-step multiplies before
// its result, after a first multiply of its own when that box itself goes through the multiplier.
// A frame end without a target goes to the output stage with no division or multiply. One item at a time.
// Reset (async, active low): registers to defaults, tracked box cleared, no result pending.
module visual_servo_target_control_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vstc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [vstc_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [vstc_pkg::CoordBits-1:0]      left_edge_i,
  input  logic [vstc_pkg::CoordBits-1:0]      top_edge_i,
  input  logic [vstc_pkg::CoordBits-1:0]      right_edge_i,
  input  logic [vstc_pkg::CoordBits-1:0]      bottom_edge_i,
  input  logic [7:0]                          box_class_i,
  input  logic                                box_present_i,
  input  logic                                frame_end_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [vstc_pkg::ErrW-1:0]    yaw_command_o,
  output logic signed [vstc_pkg::ErrW-1:0]    vertical_command_o,
  output logic signed [vstc_pkg::ErrW-1:0]    forward_command_o,
  output logic                                target_found_o
);

  localparam int CoordW  = vstc_pkg::CoordBits;
  localparam int SumW    = vstc_pkg::SumW;
  localparam int AreaW   = vstc_pkg::AreaW;
  localparam int DimW    = vstc_pkg::DimW;
  localparam int ErrW    = vstc_pkg::ErrW;
  localparam int MulW    = vstc_pkg::MulW;
  localparam int DivW    = vstc_pkg::DivW;
  localparam int DenW    = vstc_pkg::DenW;
  localparam int QuoW    = vstc_pkg::QuoW;
  localparam int DiffW   = vstc_pkg::DiffW;
  localparam int OffMagW = vstc_pkg::OffMagW;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_AREA = 4'd1;
  localparam logic [3:0] ST_FEND = 4'd2;
  localparam logic [3:0] ST_DIVX = 4'd3;
  localparam logic [3:0] ST_DIVY = 4'd4;
  localparam logic [3:0] ST_WH   = 4'd5;
  localparam logic [3:0] ST_DIVD = 4'd6;
  localparam logic [3:0] ST_MULX = 4'd7;
  localparam logic [3:0] ST_MULY = 4'd8;
  localparam logic [3:0] ST_MULD = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  typedef struct packed {
    logic            neg;
    logic [ErrW-1:0] mag;
  } err_t;

  // saturated magnitude of a truncated centre offset quotient
  function automatic logic [ErrW-1:0] err_from_quo(input logic [QuoW-1:0] quo,
                                                    input logic ovf, input logic neg);
    logic [ErrW-1:0] r;
    if (neg) begin
      r = (ovf || quo > QuoW'(32'd32768)) ? 16'h8000 : quo[ErrW-1:0];
    end else begin
      r = (ovf || quo > QuoW'(32'd32767)) ? 16'h7fff : quo[ErrW-1:0];
    end
    return r;
  endfunction

  // wanted ratio minus measured ratio, saturated
  function automatic err_t ratio_err(input logic [QuoW-1:0] quo, input logic ovf,
                                     input logic [13:0] want);
    err_t            r;
    logic [QuoW-1:0] over;
    over = quo - QuoW'(want);
    if (ovf || quo > QuoW'(want)) begin
      r.neg = 1'b1;
      r.mag = (ovf || over > QuoW'(32'd32768)) ? 16'h8000 : over[ErrW-1:0];
    end else begin
      r.neg = 1'b0;
      r.mag = {2'b00, want - quo[13:0]};
    end
    return r;
  endfunction

  // floor of signed product / 2^14, saturated to Q8.8
  function automatic logic [ErrW-1:0] cmd_sat(input logic [30:0] m, input logic neg);
    logic [30:0]     t;
    logic [16:0]     q;
    logic [ErrW-1:0] r;
    if (!neg) begin
      t = m;
      q = t[30:14];
      r = (q > 17'd32767) ? 16'h7fff : q[15:0];
    end else begin
      t = m + 31'd16383;
      q = t[30:14];
      r = (q > 17'd32768) ? 16'h8000 : 16'd0 - q[15:0];
    end
    return r;
  endfunction

  function automatic logic [ErrW-1:0] mag16(input logic [ErrW-1:0] g);
    return g[ErrW-1] ? 16'd0 - g : g;
  endfunction

  // registers
  logic [3:0]        state_q, state_d;
  logic [7:0]        tc_q;
  logic [15:0]       db_q, ga_q, gl_q, gd_q, war_q;
  logic [DimW-1:0]   iw_q, ih_q;
  logic [AreaW-1:0]  best_area_q;
  logic [SumW-1:0]   best_xs_q, best_ys_q, cand_xs_q, cand_ys_q;
  logic              have_q, last_q;
  err_t              ex_q, ey_q, ed_q;
  logic [ErrW-1:0]   cx_q, cy_q, cd_q;
  logic              out_valid_q;
  logic [ErrW-1:0]   yaw_q, vert_q, fwd_q;
  logic              found_q;

  // datapath
  vstc_pkg::mul_req_t mreq;
  vstc_pkg::mul_res_t mres;
  vstc_pkg::div_req_t dreq;
  vstc_pkg::div_res_t dres;

  logic              in_xfer, out_free, out_load, box_hit, area_win;
  logic [CoordW:0]   box_w, box_h, box_w_abs, box_h_abs;
  logic [DimW-1:0]   w_eff, h_eff;
  logic [DiffW-1:0]  offx, offy, offx_abs, offy_abs;
  logic              offx_neg, offy_neg, cerr_neg, cmd_neg;
  logic [ErrW-1:0]   cerr_raw, cmd_cur;
  err_t              cerr, derr, derr_raw;

  vstc_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .res_o  (mres)
  );

  vstc_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .res_o  (dres)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign out_load   = (state_q == ST_OUT) & out_free;

  always_comb begin
    w_eff = (iw_q == '0) ? DimW'(1) : iw_q;
    h_eff = (ih_q == '0) ? DimW'(1) : ih_q;

    box_w     = {1'b0, right_edge_i} - {1'b0, left_edge_i};
    box_h     = {1'b0, bottom_edge_i} - {1'b0, top_edge_i};
    box_w_abs = box_w[CoordW] ? -box_w : box_w;
    box_h_abs = box_h[CoordW] ? -box_h : box_h;
    // positive area: both sides non-zero with the same sign
    box_hit   = box_present_i & (box_class_i == tc_q) & (box_w != '0) & (box_h != '0)
              & (box_w[CoordW] == box_h[CoordW]);
    area_win  = (mres.prod[AreaW-1:0] > best_area_q);

    offx     = DiffW'(best_xs_q) - DiffW'({w_eff, 4'b0000});
    offy     = DiffW'(best_ys_q) - DiffW'({h_eff, 4'b0000});
    offx_neg = offx[DiffW-1];
    offy_neg = offy[DiffW-1];
    offx_abs = offx_neg ? -offx : offx;
    offy_abs = offy_neg ? -offy : offy;

    cerr_neg = (state_q == ST_DIVY) ? offy_neg : offx_neg;
    cerr_raw = err_from_quo(dres.quo, dres.ovf, cerr_neg);
    cerr.neg = cerr_neg;
    cerr.mag = ({cerr_raw, 1'b0} < {1'b0, db_q}) ? '0 : cerr_raw;

    // depth band is half as wide
    derr_raw = ratio_err(dres.quo, dres.ovf, war_q[15:2]);
    derr.neg = derr_raw.neg;
    derr.mag = ({derr_raw.mag, 2'b00} < {2'b00, db_q}) ? '0 : derr_raw.mag;

    case (state_q)
      ST_MULX: cmd_neg = ex_q.neg ^ ga_q[15];
      ST_MULY: cmd_neg = ~(ey_q.neg ^ gl_q[15]);
      default: cmd_neg = ed_q.neg ^ gd_q[15];
    endcase
    cmd_cur = cmd_sat(mres.prod[30:0], cmd_neg);
  end

  always_comb begin
    state_d = state_q;
    mreq    = '0;
    dreq    = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (box_hit) begin
            mreq.start = 1'b1;
            mreq.a     = MulW'(box_w_abs[CoordW-1:0]);
            mreq.b     = MulW'(box_h_abs[CoordW-1:0]);
            state_d    = ST_AREA;
          end else if (frame_end_i) begin
            state_d = ST_FEND;
          end
        end
      end
      ST_AREA: begin
        if (mres.done) begin
          state_d = last_q ? ST_FEND : ST_IDLE;
        end
      end
      ST_FEND: begin
        if (have_q) begin
          dreq.start = 1'b1;
          dreq.num   = DivW'({offx_abs[OffMagW-1:0], 10'b0});
          dreq.den   = DenW'(w_eff);
          state_d    = ST_DIVX;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIVX: begin
        if (dres.done) begin
          dreq.start = 1'b1;
          dreq.num   = DivW'({offy_abs[OffMagW-1:0], 10'b0});
          dreq.den   = DenW'(h_eff);
          state_d    = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (dres.done) begin
          mreq.start = 1'b1;
          mreq.a     = MulW'(w_eff);
          mreq.b     = MulW'(h_eff);
          state_d    = ST_WH;
        end
      end
      ST_WH: begin
        if (mres.done) begin
          dreq.start = 1'b1;
          dreq.num   = DivW'({best_area_q, 6'b0});
          dreq.den   = mres.prod[DenW-1:0];
          state_d    = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (dres.done) begin
          mreq.start = 1'b1;
          mreq.a     = MulW'(ex_q.mag);
          mreq.b     = MulW'(mag16(ga_q));
          state_d    = ST_MULX;
        end
      end
      ST_MULX: begin
        if (mres.done) begin
          mreq.start = 1'b1;
          mreq.a     = MulW'(ey_q.mag);
          mreq.b     = MulW'(mag16(gl_q));
          state_d    = ST_MULY;
        end
      end
      ST_MULY: begin
        if (mres.done) begin
          mreq.start = 1'b1;
          mreq.a     = MulW'(ed_q.mag);
          mreq.b     = MulW'(mag16(gd_q));
          state_d    = ST_MULD;
        end
      end
      ST_MULD: begin
        if (mres.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tc_q        <= vstc_pkg::RstTargetClass;
      db_q        <= vstc_pkg::RstDeadband;
      ga_q        <= vstc_pkg::RstGain;
      gl_q        <= vstc_pkg::RstGain;
      gd_q        <= vstc_pkg::RstGain;
      war_q       <= vstc_pkg::RstWantedRatio;
      iw_q        <= vstc_pkg::RstImageDim;
      ih_q        <= vstc_pkg::RstImageDim;
      best_area_q <= '0;
      best_xs_q   <= '0;
      best_ys_q   <= '0;
      have_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          vstc_pkg::RegTargetClass: tc_q  <= cfg_data_i[7:0];
          vstc_pkg::RegDeadband:    db_q  <= cfg_data_i;
          vstc_pkg::RegGainAngular: ga_q  <= cfg_data_i;
          vstc_pkg::RegGainLinear:  gl_q  <= cfg_data_i;
          vstc_pkg::RegGainDepth:   gd_q  <= cfg_data_i;
          vstc_pkg::RegWantedRatio: war_q <= cfg_data_i;
          vstc_pkg::RegImageWidth:  iw_q  <= cfg_data_i[DimW-1:0];
          vstc_pkg::RegImageHeight: ih_q  <= cfg_data_i[DimW-1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        last_q <= frame_end_i;
      end
      // strictly larger area replaces the tracked box
      if (state_q == ST_AREA && mres.done && area_win) begin
        best_area_q <= mres.prod[AreaW-1:0];
        best_xs_q   <= cand_xs_q;
        best_ys_q   <= cand_ys_q;
        have_q      <= 1'b1;
      end
      if (out_load) begin
        best_area_q <= '0;
        best_xs_q   <= '0;
        best_ys_q   <= '0;
        have_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cand_xs_q <= {1'b0, left_edge_i} + {1'b0, right_edge_i};
      cand_ys_q <= {1'b0, top_edge_i} + {1'b0, bottom_edge_i};
    end
    if (state_q == ST_DIVX && dres.done) begin
      ex_q <= cerr;
    end
    if (state_q == ST_DIVY && dres.done) begin
      ey_q <= cerr;
    end
    if (state_q == ST_DIVD && dres.done) begin
      ed_q <= derr;
    end
    if (state_q == ST_MULX && mres.done) begin
      cx_q <= cmd_cur;
    end
    if (state_q == ST_MULY && mres.done) begin
      cy_q <= cmd_cur;
    end
    if (state_q == ST_MULD && mres.done) begin
      cd_q <= cmd_cur;
    end
    if (out_load) begin
      yaw_q   <= have_q ? cx_q : '0;
      vert_q  <= have_q ? cy_q : '0;
      fwd_q   <= have_q ? cd_q : '0;
      found_q <= have_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign yaw_command_o      = $signed(yaw_q);
  assign vertical_command_o = $signed(vert_q);
  assign forward_command_o  = $signed(fwd_q);
  assign target_found_o     = found_q;

endmodule

FILE: tb/visual_servo_target_control_core_tb.sv
// Self-checking testbench for the servo target core: box tracking and command prediction.
`timescale 1ns / 100ps

module visual_servo_target_control_core_tb;

  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned MaxPrinted = 30;

  typedef struct {
    logic [vstc_pkg::CoordBits-1:0] left_x;
    logic [vstc_pkg::CoordBits-1:0] top_y;
    logic [vstc_pkg::CoordBits-1:0] right_x;
    logic [vstc_pkg::CoordBits-1:0] bottom_y;
    logic [7:0]                     cls;
    logic                           has_box;
    logic                           frame_end;
  } box_item_t;

  typedef struct {
    logic signed [vstc_pkg::ErrW-1:0] yaw;
    logic signed [vstc_pkg::ErrW-1:0] vert;
    logic signed [vstc_pkg::ErrW-1:0] fwd;
    logic                             found;
  } command_t;

  typedef struct {
    logic [7:0]                target_class;
    logic [15:0]               deadband;
    logic signed [15:0]        gain_yaw;
    logic signed [15:0]        gain_vert;
    logic signed [15:0]        gain_fwd;
    logic [15:0]               wanted_ratio;
    logic [vstc_pkg::DimW-1:0] img_w;
    logic [vstc_pkg::DimW-1:0] img_h;
  } servo_cfg_t;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             cfg_we_i      = 1'b0;
  logic [vstc_pkg::CfgIdxW-1:0]     cfg_index_i   = '0;
  logic [vstc_pkg::CfgDataW-1:0]    cfg_data_i    = '0;
  logic                             in_valid_i    = 1'b0;
  logic                             in_ready_o;
  logic [vstc_pkg::CoordBits-1:0]   left_edge_i   = '0;
  logic [vstc_pkg::CoordBits-1:0]   top_edge_i    = '0;
  logic [vstc_pkg::CoordBits-1:0]   right_edge_i  = '0;
  logic [vstc_pkg::CoordBits-1:0]   bottom_edge_i = '0;
  logic [7:0]                       box_class_i   = '0;
  logic                             box_present_i = 1'b0;
  logic                             frame_end_i   = 1'b0;
  logic                             out_valid_o;
  logic                             out_ready_i   = 1'b0;
  logic signed [vstc_pkg::ErrW-1:0] yaw_command_o;
  logic signed [vstc_pkg::ErrW-1:0] vertical_command_o;
  logic signed [vstc_pkg::ErrW-1:0] forward_command_o;
  logic                             target_found_o;

  visual_servo_target_control_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .left_edge_i        (left_edge_i),
    .top_edge_i         (top_edge_i),
    .right_edge_i       (right_edge_i),
    .bottom_edge_i      (bottom_edge_i),
    .box_class_i        (box_class_i),
    .box_present_i      (box_present_i),
    .frame_end_i        (frame_end_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .yaw_command_o      (yaw_command_o),
    .vertical_command_o (vertical_command_o),
    .forward_command_o  (forward_command_o),
    .target_found_o     (target_found_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: configuration copy, the best box of the current frame and the expected commands
  servo_cfg_t                 cfg;
  logic [vstc_pkg::AreaW-1:0] best_area;
  logic [vstc_pkg::SumW-1:0]  best_x_sum;
  logic [vstc_pkg::SumW-1:0]  best_y_sum;
  bit                         have_target;
  command_t                   pending_commands[$];
  box_item_t                  prior_box;

  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned cycle_count   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned sink_hold_req = 0;
  int unsigned sink_stall    = 0;

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint abs_val(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Q2.14 centre offset, truncated toward zero
  function automatic longint centre_offset(longint sum, longint size);
    longint num;
    num = (sum - size * 16) * 1024;
    return clamp16(num / size);
  endfunction

  // floor(err * gain / 2^14), rounded toward minus infinity after optional negation
  function automatic logic signed [vstc_pkg::ErrW-1:0] scale_error(longint err, longint gain,
                                                                    bit negate);
    longint p;
    longint q;
    p = err * gain;
    if (negate) p = -p;
    if (p < 0) q = -((-p + 16383) >>> 14);
    else q = p >>> 14;
    return 16'(clamp16(q));
  endfunction

  function automatic void clear_frame();
    best_area   = '0;
    best_x_sum  = '0;
    best_y_sum  = '0;
    have_target = 1'b0;
  endfunction

  function automatic void absorb_box(box_item_t b);
    longint   w;
    longint   h;
    longint   area;
    longint   wd;
    longint   ht;
    longint   ex;
    longint   ey;
    longint   ed;
    longint   ratio;
    command_t c;
    if (b.has_box && b.cls == cfg.target_class) begin
      w    = longint'(b.right_x) - longint'(b.left_x);
      h    = longint'(b.bottom_y) - longint'(b.top_y);
      area = w * h;
      // strictly greater only: an equal later box keeps the earlier one
      if (area > 0 && area > longint'(best_area)) begin
        best_area   = area[vstc_pkg::AreaW-1:0];
        best_x_sum  = {1'b0, b.left_x} + {1'b0, b.right_x};
        best_y_sum  = {1'b0, b.top_y} + {1'b0, b.bottom_y};
        have_target = 1'b1;
      end
    end
    if (!b.frame_end) return;
    c.yaw   = '0;
    c.vert  = '0;
    c.fwd   = '0;
    c.found = 1'b0;
    if (have_target) begin
      wd    = (cfg.img_w == 0) ? 1 : longint'(cfg.img_w);
      ht    = (cfg.img_h == 0) ? 1 : longint'(cfg.img_h);
      ex    = centre_offset(longint'(best_x_sum), wd);
      ey    = centre_offset(longint'(best_y_sum), ht);
      ratio = (longint'(best_area) * 64) / (wd * ht);
      ed    = clamp16(longint'(cfg.wanted_ratio) / 4 - ratio);
      if (2 * abs_val(ex) < longint'(cfg.deadband)) ex = 0;
      if (2 * abs_val(ey) < longint'(cfg.deadband)) ey = 0;
      // depth band is half as wide
      if (4 * abs_val(ed) < longint'(cfg.deadband)) ed = 0;
      c.yaw   = scale_error(ex, longint'(cfg.gain_yaw), 1'b0);
      c.vert  = scale_error(ey, longint'(cfg.gain_vert), 1'b1);
      c.fwd   = scale_error(ed, longint'(cfg.gain_fwd), 1'b0);
      c.found = 1'b1;
    end
    pending_commands.push_back(c);
    clear_frame();
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("t=%0t result %0d: %s got %0d expected %0d",
               $time, results_seen, what, got, want);
  endtask

  // both handshakes are sampled mid-cycle; the transfer happens at the next rising edge
  always @(negedge clk_i) begin : watch_transfers
    command_t  want;
    box_item_t seen;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_commands.size() == 0) begin
          report_mismatch("transfer with nothing pending", 1, 0);
        end else begin
          want = pending_commands.pop_front();
          if (yaw_command_o !== want.yaw)
            report_mismatch("yaw_command", yaw_command_o, want.yaw);
          if (vertical_command_o !== want.vert)
            report_mismatch("vertical_command", vertical_command_o, want.vert);
          if (forward_command_o !== want.fwd)
            report_mismatch("forward_command", forward_command_o, want.fwd);
          if (target_found_o !== want.found)
            report_mismatch("target_found", target_found_o, want.found);
        end
      end
      if (in_valid_i && in_ready_o) begin
        seen.left_x    = left_edge_i;
        seen.top_y     = top_edge_i;
        seen.right_x   = right_edge_i;
        seen.bottom_y  = bottom_edge_i;
        seen.cls       = box_class_i;
        seen.has_box   = box_present_i;
        seen.frame_end = frame_end_i;
        absorb_box(seen);
      end
    end
  end

  // result side: random stalls, plus a long hold when one is requested
  always @(posedge clk_i) begin
    if (sink_hold_req != 0) begin
      sink_stall    = sink_hold_req;
      sink_hold_req = 0;
    end
    if (sink_stall != 0) begin
      out_ready_i <= 1'b0;
      sink_stall--;
    end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
      out_ready_i <= 1'b0;
      sink_stall = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("t=%0t timeout with %0d results pending", $time, pending_commands.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  // called at a rising edge; returns at the edge that completes the transfer
  task automatic send_item(box_item_t b, int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    left_edge_i   <= b.left_x;
    top_edge_i    <= b.top_y;
    right_edge_i  <= b.right_x;
    bottom_edge_i <= b.bottom_y;
    box_class_i   <= b.cls;
    box_present_i <= b.has_box;
    frame_end_i   <= b.frame_end;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_box(int unsigned lx, int unsigned ty, int unsigned rx, int unsigned by,
                          logic [7:0] cls, logic has_box, logic frame_end);
    box_item_t b;
    b.left_x    = 16'(lx);
    b.top_y     = 16'(ty);
    b.right_x   = 16'(rx);
    b.bottom_y  = 16'(by);
    b.cls       = cls;
    b.has_box   = has_box;
    b.frame_end = frame_end;
    send_item(b, pick_gap(20));
  endtask

  task automatic drain(int unsigned settle);
    in_valid_i <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [vstc_pkg::CfgIdxW-1:0] idx,
                           logic [vstc_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  // only while idle: every register is rewritten each time
  task automatic program_config(servo_cfg_t c);
    write_reg(vstc_pkg::RegTargetClass, {8'd0, c.target_class});
    write_reg(vstc_pkg::RegDeadband, c.deadband);
    write_reg(vstc_pkg::RegGainAngular, c.gain_yaw);
    write_reg(vstc_pkg::RegGainLinear, c.gain_vert);
    write_reg(vstc_pkg::RegGainDepth, c.gain_fwd);
    write_reg(vstc_pkg::RegWantedRatio, c.wanted_ratio);
    write_reg(vstc_pkg::RegImageWidth, {3'd0, c.img_w});
    write_reg(vstc_pkg::RegImageHeight, {3'd0, c.img_h});
    cfg_we_i <= 1'b0;
    cfg = c;
  endtask

  function automatic logic signed [15:0] pick_gain(bit extremes);
    if (extremes) begin
      case ($urandom_range(3))
        0: return -16'sd32768;
        1: return 16'sd32767;
        2: return 16'($urandom_range(65535));
        default: ;
      endcase
    end
    return 16'(int'($urandom_range(4096)) - 2048);
  endfunction

  function automatic logic [vstc_pkg::DimW-1:0] pick_dim(bit extremes);
    if (extremes) begin
      case ($urandom_range(5))
        0: return '0;
        1: return 13'd1;
        2: return 13'd4096;
        default: ;
      endcase
    end
    return 13'($urandom_range(1024, 64));
  endfunction

  function automatic servo_cfg_t random_cfg(bit extremes);
    servo_cfg_t c;
    c.target_class = 8'($urandom_range(255));
    c.deadband     = 16'($urandom_range(4096));
    c.wanted_ratio = 16'($urandom_range(65535));
    if (extremes) begin
      case ($urandom_range(2))
        0: c.deadband = 16'd0;
        1: c.deadband = 16'd32768;
        default: c.deadband = 16'($urandom_range(32768));
      endcase
      case ($urandom_range(2))
        0: c.wanted_ratio = 16'd0;
        1: c.wanted_ratio = 16'd65535;
        default: ;
      endcase
    end
    c.gain_yaw  = pick_gain(extremes);
    c.gain_vert = pick_gain(extremes);
    c.gain_fwd  = pick_gain(extremes);
    c.img_w     = pick_dim(extremes);
    c.img_h     = pick_dim(extremes);
    return c;
  endfunction

  function automatic box_item_t random_box();
    box_item_t   b;
    int unsigned pick;
    int unsigned span_x;
    int unsigned span_y;
    int unsigned a;
    int unsigned c;
    int unsigned d;
    logic [15:0] t;
    pick   = $urandom_range(99);
    span_x = (cfg.img_w == 0) ? 16 : 16 * cfg.img_w;
    span_y = (cfg.img_h == 0) ? 16 : 16 * cfg.img_h;
    if (span_x > 65536) span_x = 65536;
    if (span_y > 65536) span_y = 65536;
    b.cls       = cfg.target_class;
    b.has_box   = 1'b1;
    b.frame_end = 1'b0;
    a = $urandom_range(span_x - 1);
    c = $urandom_range(span_x - 1);
    b.left_x  = 16'((a < c) ? a : c);
    b.right_x = 16'((a < c) ? c : a);
    a = $urandom_range(span_y - 1);
    c = $urandom_range(span_y - 1);
    b.top_y    = 16'((a < c) ? a : c);
    b.bottom_y = 16'((a < c) ? c : a);
    if (pick < 55) begin
      prior_box = b;
    end else if (pick < 65) begin
      b.left_x   = 16'($urandom_range(65535));
      b.top_y    = 16'($urandom_range(65535));
      b.right_x  = 16'($urandom_range(65535));
      b.bottom_y = 16'($urandom_range(65535));
    end else if (pick < 73) begin
      // inverted in one or both directions
      d = $urandom_range(2);
      if (d != 1) begin
        t = b.left_x; b.left_x = b.right_x; b.right_x = t;
      end
      if (d != 0) begin
        t = b.top_y; b.top_y = b.bottom_y; b.bottom_y = t;
      end
    end else if (pick < 83) begin
      b.cls = cfg.target_class ^ 8'($urandom_range(255, 1));
    end else if (pick < 90) begin
      b.has_box  = 1'b0;
      b.cls      = ($urandom_range(1) == 0) ? cfg.target_class : 8'($urandom_range(255));
      b.left_x   = 16'($urandom_range(65535));
      b.top_y    = 16'($urandom_range(65535));
      b.right_x  = 16'($urandom_range(65535));
      b.bottom_y = 16'($urandom_range(65535));
    end else begin
      // same size as an earlier box, moved sideways where it fits
      b = prior_box;
      d = 16 * $urandom_range(8, 1);
      if (int'(b.right_x) + d <= 65535 && int'(b.left_x) + d <= 65535) begin
        b.left_x  = 16'(b.left_x + d);
        b.right_x = 16'(b.right_x + d);
      end else if (b.left_x >= d && b.right_x >= d) begin
        b.left_x  = 16'(b.left_x - d);
        b.right_x = 16'(b.right_x - d);
      end
      b.frame_end = 1'b0;
    end
    return b;
  endfunction

  task automatic send_frame(int unsigned n, int unsigned idle_pct);
    box_item_t b;
    for (int unsigned i = 0; i < n; i++) begin
      b = random_box();
      b.frame_end = (i == n - 1);
      send_item(b, pick_gap(idle_pct));
    end
  endtask

  task automatic test_empty_and_centred_frames();
    send_box(0, 0, 0, 0, 8'd0, 1'b0, 1'b1);
    send_box(16 * 300, 16 * 300, 16 * 340, 16 * 340, 8'd0, 1'b1, 1'b1);
    send_box(0, 16 * 500, 16 * 100, 16 * 640, 8'd0, 1'b1, 1'b0);
    send_box(0, 0, 0, 0, 8'd0, 1'b0, 1'b1);
    drain(8);
  endtask

  task automatic test_box_corner_cases();
    send_box(0, 0, 65535, 65535, 8'd0, 1'b1, 1'b1);
    // zero area never wins
    send_box(1600, 1600, 1600, 4800, 8'd0, 1'b1, 1'b1);
    // inverted both ways gives a positive area
    send_box(65535, 65535, 0, 0, 8'd0, 1'b1, 1'b1);
    send_box(16 * 400, 0, 16 * 100, 16 * 100, 8'd0, 1'b1, 1'b0);
    send_box(0, 0, 0, 0, 8'd0, 1'b0, 1'b1);
    // equal area: the first stays
    send_box(0, 0, 1600, 1600, 8'd0, 1'b1, 1'b0);
    send_box(3200, 3200, 4800, 4800, 8'd0, 1'b1, 1'b1);
    send_box(0, 0, 160, 160, 8'd0, 1'b1, 1'b0);
    send_box(3200, 1600, 8000, 6400, 8'd0, 1'b1, 1'b0);
    send_box(0, 0, 4800, 320, 8'd0, 1'b1, 1'b1);
    send_box(0, 0, 65535, 65535, 8'd255, 1'b1, 1'b0);
    send_box(0, 0, 9000, 9000, 8'd0, 1'b0, 1'b1);
    drain(8);
  endtask

  task automatic test_image_size_extremes();
    servo_cfg_t c;
    c.target_class = 8'd255;
    c.deadband     = 16'd0;
    c.gain_yaw     = 16'sd32767;
    c.gain_vert    = -16'sd32768;
    c.gain_fwd     = 16'sd32767;
    c.wanted_ratio = 16'd65535;
    c.img_w        = '0;
    c.img_h        = '0;
    program_config(c);
    send_box(16, 16, 48, 48, 8'd255, 1'b1, 1'b1);
    send_box(0, 0, 65535, 65535, 8'd255, 1'b1, 1'b1);
    drain(8);
    c.target_class = 8'd128;
    c.deadband     = 16'd32768;
    c.gain_yaw     = -16'sd32768;
    c.gain_vert    = 16'sd32767;
    c.gain_fwd     = -16'sd32768;
    c.wanted_ratio = 16'd0;
    c.img_w        = 13'd4096;
    c.img_h        = 13'd4096;
    program_config(c);
    send_box(0, 0, 32, 32, 8'd128, 1'b1, 1'b1);
    send_box(0, 0, 65535, 65535, 8'd128, 1'b1, 1'b1);
    c.deadband = 16'd0;
    drain(8);
    program_config(c);
    send_box(65000, 65000, 65535, 65535, 8'd128, 1'b1, 1'b1);
    drain(8);
  endtask

  // the sink holds off while frames keep coming, so the core backs up its input
  task automatic test_sink_backpressure();
    program_config(random_cfg(1'b0));
    sink_stall_pct = 0;
    sink_hold_req  = 600;
    for (int i = 0; i < 10; i++) send_frame($urandom_range(3, 1), 0);
    drain(8);
  endtask

  task automatic test_source_pause();
    sink_stall_pct = 25;
    for (int i = 0; i < 6; i++) begin
      send_frame($urandom_range(4, 1), 30);
      send_frame($urandom_range(4, 1), 30);
      drain(0);
    end
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned n;
    int unsigned idle_pct;
    for (int phase = 0; phase < 12; phase++) begin
      drain(16);
      program_config(random_cfg(phase % 2 == 1));
      // every third phase runs with no idling on either side
      idle_pct       = (phase % 3 == 2) ? 0 : $urandom_range(40, 10);
      sink_stall_pct = (phase % 3 == 2) ? 0 : $urandom_range(40, 10);
      sent = 0;
      while (sent < 98) begin
        n = $urandom_range(6, 1);
        send_frame(n, idle_pct);
        sent += n;
      end
    end
  endtask

  initial begin
    cfg = '{target_class: vstc_pkg::RstTargetClass, deadband: vstc_pkg::RstDeadband,
            gain_yaw: vstc_pkg::RstGain, gain_vert: vstc_pkg::RstGain,
            gain_fwd: vstc_pkg::RstGain, wanted_ratio: vstc_pkg::RstWantedRatio,
            img_w: vstc_pkg::RstImageDim, img_h: vstc_pkg::RstImageDim};
    clear_frame();
    prior_box = '{default: '0};
    sink_stall_pct = 20;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_centred_frames();
    test_box_corner_cases();
    test_image_size_extremes();
    test_sink_backpressure();
    test_source_pause();
    test_random_frames();
    drain(200);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: visual_servo_target_control_core.f
rtl/core/vstc_pkg.sv
rtl/core/vstc_serial_mul.sv
rtl/core/vstc_serial_div.sv
rtl/core/visual_servo_target_control_core.sv
tb/visual_servo_target_control_core_tb.sv
